/* rtl/core/mh2_pkg.sv */
// Shared types and constants for the MurmurHash2 engine.
`timescale 1ns / 1ps

package mh2_pkg;

	localparam int WORD_W      = 32;
	localparam int BYTES_W     = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1e995;
	localparam int MIX_SHIFT   = 24;
	localparam int FIN_SHIFT_A = 13;
	localparam int FIN_SHIFT_B = 15;

	localparam logic [BYTES_W-1:0] FULL_BYTES = 3'd4;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_TAIL,
		KIND_FULL
	} kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		kind_t             kind;
		logic              first;
		logic              last;
		logic [WORD_W-1:0] start;
	} entry_t;

endpackage

/* rtl/core/mh2_if.sv */
// Valid/ready channel interfaces for key words in and hashes out.
`timescale 1ns / 1ps

interface mh2_in_if;
	logic                                valid;
	logic                                ready;
	logic [mh2_pkg::WORD_W-1:0]          data_word;
	logic [mh2_pkg::BYTES_W-1:0]         valid_bytes;
	logic                                first;
	logic                                last;
	logic [mh2_pkg::WORD_W-1:0]          key_length;

	modport source (output valid, data_word, valid_bytes, first, last, key_length,
		input ready);
	modport sink (input valid, data_word, valid_bytes, first, last, key_length,
		output ready);
endinterface

interface mh2_out_if;
	logic                       valid;
	logic                       ready;
	logic [mh2_pkg::WORD_W-1:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

/* rtl/core/mh2_front.sv */
// Front end: seed register, input transfer and word classification.
`timescale 1ns / 1ps

module mh2_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [mh2_pkg::WORD_W-1:0] cfg_wr_data,
	mh2_in_if.sink                     in_ch,
	input  logic                       q_full,
	output logic                       q_push,
	output mh2_pkg::entry_t            q_entry
);

	logic [mh2_pkg::WORD_W-1:0] seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	always_comb begin
		q_entry.first = in_ch.first;
		q_entry.last  = in_ch.last;
		q_entry.start = seed_q ^ in_ch.key_length;
		q_entry.word  = in_ch.data_word;
		q_entry.kind  = mh2_pkg::KIND_FULL;
		priority if (in_ch.valid_bytes >= mh2_pkg::FULL_BYTES) begin
			q_entry.kind = mh2_pkg::KIND_FULL;
		end else if (in_ch.valid_bytes == 3'd3) begin
			q_entry.kind = mh2_pkg::KIND_TAIL;
			q_entry.word = in_ch.data_word & 32'h00ff_ffff;
		end else if (in_ch.valid_bytes == 3'd2) begin
			q_entry.kind = mh2_pkg::KIND_TAIL;
			q_entry.word = in_ch.data_word & 32'h0000_ffff;
		end else if (in_ch.valid_bytes == 3'd1) begin
			q_entry.kind = mh2_pkg::KIND_TAIL;
			q_entry.word = in_ch.data_word & 32'h0000_00ff;
		end else begin
			q_entry.kind = mh2_pkg::KIND_NONE;
			q_entry.word = '0;
		end
	end

endmodule

/* rtl/core/mh2_queue.sv */
// Small first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps

module mh2_queue #(
	parameter int DEPTH = mh2_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mh2_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output mh2_pkg::entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	mh2_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/mh2_back.sv */
// Back end: word mixing, hash fold, finalization and the result register.
`timescale 1ns / 1ps

module mh2_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  mh2_pkg::entry_t q_head,
	output logic            q_pop,
	mh2_out_if.source       out_ch
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [mh2_pkg::WORD_W-1:0] running_hash_q;
	logic [mh2_pkg::WORD_W-1:0] cur_h_q;
	logic [mh2_pkg::WORD_W-1:0] prod_w_q;
	logic [mh2_pkg::WORD_W-1:0] prod_h_q;
	logic [mh2_pkg::WORD_W-1:0] fin_q;
	mh2_pkg::kind_t             kind_q;
	logic                       last_q;
	logic                       out_valid_q;
	logic [mh2_pkg::WORD_W-1:0] out_hash_q;

	logic [mh2_pkg::WORD_W-1:0] h_in;
	logic [mh2_pkg::WORD_W-1:0] h_mul_src;
	logic [mh2_pkg::WORD_W-1:0] w_shift;
	logic [mh2_pkg::WORD_W-1:0] w_mixed;
	logic [mh2_pkg::WORD_W-1:0] fin_src;
	logic                       out_free;

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign h_in   = q_head.first ? q_head.start : running_hash_q;
	assign h_mul_src = (q_head.kind == mh2_pkg::KIND_TAIL) ? (h_in ^ q_head.word) : h_in;
	assign w_shift = prod_w_q ^ (prod_w_q >> mh2_pkg::MIX_SHIFT);
	assign w_mixed = w_shift * mh2_pkg::MIX_MUL;
	assign fin_src = running_hash_q ^ (running_hash_q >> mh2_pkg::FIN_SHIFT_A);
	assign out_free = !out_valid_q || out_ch.ready;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.hash_value = out_hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			running_hash_q <= '0;
			cur_h_q        <= '0;
			prod_w_q       <= '0;
			prod_h_q       <= '0;
			fin_q          <= '0;
			kind_q         <= mh2_pkg::KIND_NONE;
			last_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			out_hash_q     <= '0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_h_q  <= h_in;
						kind_q   <= q_head.kind;
						last_q   <= q_head.last;
						prod_w_q <= q_head.word * mh2_pkg::MIX_MUL;
						prod_h_q <= h_mul_src * mh2_pkg::MIX_MUL;
						state_q  <= ST_MIX;
					end
				end
				ST_MIX: begin
					unique case (kind_q)
						mh2_pkg::KIND_FULL: running_hash_q <= prod_h_q ^ w_mixed;
						mh2_pkg::KIND_TAIL: running_hash_q <= prod_h_q;
						default:            running_hash_q <= cur_h_q;
					endcase
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					fin_q   <= fin_src * mh2_pkg::MIX_MUL;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_hash_q  <= fin_q ^ (fin_q >> mh2_pkg::FIN_SHIFT_B);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/murmur2_hash_engine_top.sv */
// Top level of the streaming 32-bit MurmurHash2 engine.
// The back end takes a new item only in ST_IDLE, after the mix/fold multiplier pair is done with the last one.
// A last item also passes through ST_FIN for the finalize multiply and ST_OUT for the result register load.
// A result is registered through the queue, ST_IDLE, ST_MIX, ST_FIN and ST_OUT before out_ch.valid rises.
// Reset (arst_n low) clears the seed, running hash, queue and result valid at once.
`timescale 1ns / 1ps

module murmur2_hash_engine_top #(
	parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [mh2_pkg::WORD_W-1:0] cfg_wr_data,
	mh2_in_if.sink                     in_ch,
	mh2_out_if.source                  out_ch
);

	logic            q_full;
	logic            q_push;
	mh2_pkg::entry_t q_entry;
	logic            q_pop;
	logic            q_valid;
	mh2_pkg::entry_t q_head;

	mh2_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	mh2_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	mh2_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

/* sim/murmur2_hash_engine_top_tb.sv */
// Self-checking testbench for the streaming MurmurHash2 engine: random keys under several seeds.
`timescale 1ns / 1ps

module murmur2_hash_engine_top_tb;
	import mh2_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 330;

	typedef struct {
		logic [WORD_W-1:0]  word;
		logic [BYTES_W-1:0] nbytes;
		logic               first;
		logic               last;
		logic [WORD_W-1:0]  klen;
	} key_word_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_RUNS
	} ready_mode_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [WORD_W-1:0] cfg_wr_data;

	mh2_in_if  in_ch();
	mh2_out_if out_ch();

	murmur2_hash_engine_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	key_word_t         pending_words[$];
	logic [WORD_W-1:0] expected_hashes[$];
	logic [WORD_W-1:0] seed_shadow  = '0;
	logic [WORD_W-1:0] hash_shadow  = '0;
	bit                in_accepted  = 1'b0;
	int unsigned       words_queued = 0;
	int unsigned       words_taken  = 0;
	int unsigned       hashes_seen  = 0;
	int unsigned       mismatches   = 0;
	int unsigned       seed_writes  = 0;
	int unsigned       stall_cycles = 0;

	function automatic logic [WORD_W-1:0] fold_key_word(input logic [WORD_W-1:0] h,
		input logic [WORD_W-1:0] seed_val, input key_word_t kw);
		logic [WORD_W-1:0]  acc;
		logic [WORD_W-1:0]  mixed;
		logic [BYTES_W-1:0] n;
		n   = (kw.nbytes > FULL_BYTES) ? FULL_BYTES : kw.nbytes;
		acc = kw.first ? (seed_val ^ kw.klen) : h;
		if (n == FULL_BYTES) begin
			mixed = kw.word * MIX_MUL;
			mixed = mixed ^ (mixed >> MIX_SHIFT);
			mixed = mixed * MIX_MUL;
			acc   = (acc * MIX_MUL) ^ mixed;
		end else if (n != '0) begin
			if (n >= 3)
				acc = acc ^ {8'h00, kw.word[23:16], 16'h0000};
			if (n >= 2)
				acc = acc ^ {16'h0000, kw.word[15:8], 8'h00};
			acc = acc ^ {24'h000000, kw.word[7:0]};
			acc = acc * MIX_MUL;
		end
		return acc;
	endfunction

	function automatic logic [WORD_W-1:0] finalize_hash(input logic [WORD_W-1:0] h);
		logic [WORD_W-1:0] acc;
		acc = h ^ (h >> FIN_SHIFT_A);
		acc = acc * MIX_MUL;
		acc = acc ^ (acc >> FIN_SHIFT_B);
		return acc;
	endfunction

	task automatic push_word(input logic [WORD_W-1:0] w, input logic [BYTES_W-1:0] nb,
		input logic f, input logic l, input logic [WORD_W-1:0] kl);
		key_word_t kw;
		kw.word   = w;
		kw.nbytes = nb;
		kw.first  = f;
		kw.last   = l;
		kw.klen   = kl;
		pending_words.push_back(kw);
		words_queued++;
	endtask

	task automatic push_key(input int unsigned len, input bit drop_last);
		int unsigned        left;
		int unsigned        take;
		logic [WORD_W-1:0]  kl;
		logic [BYTES_W-1:0] nb;
		bit                 is_first;
		kl       = ($urandom_range(0, 7) == 0) ? $urandom : len;
		left     = len;
		is_first = 1'b1;
		do begin
			take = (left > 4) ? 4 : left;
			nb   = BYTES_W'(take);
			if (take == 4 && $urandom_range(0, 15) == 0)
				nb = BYTES_W'($urandom_range(5, 7));
			push_word($urandom, nb, is_first, (left <= 4) && !drop_last, kl);
			is_first = 1'b0;
			left -= take;
		end while (left != 0);
	endtask

	task automatic push_noise();
		push_word($urandom, BYTES_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic wait_drained();
		while (words_taken != words_queued || expected_hashes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		seed_writes++;
	endtask

	task automatic push_random_phase(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		stop_at = words_queued + count;
		while (words_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(0, 12);
			else if (pick < 95)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(41, 100);
			pick = $urandom_range(0, 99);
			if (pick < 85)
				push_key(len, 1'b0);
			else if (pick < 92)
				push_key(len, 1'b1);
			else
				repeat ($urandom_range(1, 3)) push_noise();
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		in_ch.valid        = 1'b0;
		in_ch.data_word    = '0;
		in_ch.valid_bytes  = '0;
		in_ch.first        = 1'b0;
		in_ch.last         = 1'b0;
		in_ch.key_length   = '0;
		out_ch.ready       = 1'b0;
	end

	// driver: bursts of transfers separated by random gaps
	always @(negedge clk) begin : drive_words
		key_word_t   kw;
		int unsigned burst_left;
		int unsigned gap_left;
		if (arst_n) begin
			if (in_ch.valid && !in_accepted) begin
			end else if (gap_left != 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				kw = pending_words.pop_front();
				in_ch.data_word   <= kw.word;
				in_ch.valid_bytes <= kw.nbytes;
				in_ch.first       <= kw.first;
				in_ch.last        <= kw.last;
				in_ch.key_length  <= kw.klen;
				in_ch.valid       <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96)
						: $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		ready_mode_t mode;
		int unsigned mode_left;
		int unsigned run_left;
		bit          run_ready;
		if (mode_left == 0) begin
			mode      = ready_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		case (mode)
			READY_ALWAYS: out_ch.ready <= 1'b1;
			READY_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
			default: begin
				if (run_left == 0) begin
					run_ready = !run_ready;
					run_left  = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 20);
				end else begin
					run_left--;
				end
				out_ch.ready <= run_ready;
			end
		endcase
	end

	always @(posedge clk) begin : track_and_check
		key_word_t         kw;
		logic [WORD_W-1:0] want;
		bit                moved;
		in_accepted = 1'b0;
		moved       = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en) begin
				seed_shadow = cfg_wr_data;
				moved       = 1'b1;
			end
			if (in_ch.valid && in_ch.ready) begin
				kw.word     = in_ch.data_word;
				kw.nbytes   = in_ch.valid_bytes;
				kw.first    = in_ch.first;
				kw.last     = in_ch.last;
				kw.klen     = in_ch.key_length;
				hash_shadow = fold_key_word(hash_shadow, seed_shadow, kw);
				if (kw.last)
					expected_hashes.push_back(finalize_hash(hash_shadow));
				in_accepted = 1'b1;
				moved       = 1'b1;
				words_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				hashes_seen++;
				if (expected_hashes.size() == 0) begin
					mismatches++;
					$display("%0t: hash %08h with nothing expected", $time, out_ch.hash_value);
				end else begin
					want = expected_hashes.pop_front();
					if (out_ch.hash_value !== want) begin
						mismatches++;
						$display("%0t: hash_value mismatch: expected %08h, actual %08h",
							$time, want, out_ch.hash_value);
					end
				end
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : run_phases
		logic [WORD_W-1:0] seeds[6];
		seeds[0] = 32'hffffffff;
		seeds[1] = 32'h00000000;
		seeds[2] = $urandom;
		seeds[3] = 32'h80000001;
		seeds[4] = $urandom;
		seeds[5] = $urandom;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// no first after reset, then a continuing partial word
		push_word(32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0);
		push_word(32'ha5a5ffff, 3'd2, 1'b0, 1'b1, 32'h0);
		// empty keys, one with a mismatched length
		push_word(32'hdeadbeef, 3'd0, 1'b1, 1'b1, 32'h0);
		push_word(32'h00000000, 3'd0, 1'b1, 1'b1, 32'hffffffff);
		// single-item keys of one to four bytes, unused bytes set
		push_word(32'hffffff80, 3'd1, 1'b1, 1'b1, 32'd1);
		push_word(32'hffff7fff, 3'd2, 1'b1, 1'b1, 32'd2);
		push_word(32'hff123456, 3'd3, 1'b1, 1'b1, 32'd3);
		push_word(32'h00000000, 3'd4, 1'b1, 1'b1, 32'd4);
		push_word(32'hffffffff, 3'd4, 1'b1, 1'b1, 32'd4);
		// five-byte key
		push_word(32'hffffffff, 3'd4, 1'b1, 1'b0, 32'd5);
		push_word(32'h000000ff, 3'd1, 1'b0, 1'b1, 32'd5);
		// oversized byte counts
		push_word(32'h12345678, 3'd7, 1'b1, 1'b1, 32'd4);
		push_word(32'h9abcdef0, 3'd5, 1'b1, 1'b0, 32'd12);
		push_word(32'h0f0f0f0f, 3'd6, 1'b0, 1'b1, 32'd12);
		// partial word in the middle of a key
		push_word(32'h11223344, 3'd2, 1'b1, 1'b0, 32'd9);
		push_word(32'h55667788, 3'd4, 1'b0, 1'b0, 32'd9);
		push_word(32'h99aabbcc, 3'd3, 1'b0, 1'b1, 32'd9);
		// continue after last without a new first
		push_word(32'h80000000, 3'd4, 1'b0, 1'b0, 32'h7fffffff);
		push_word(32'h00000001, 3'd1, 1'b0, 1'b1, 32'h7fffffff);
		push_word(32'h7fffffff, 3'd0, 1'b1, 1'b0, 32'h80000000);
		push_word(32'hcafef00d, 3'd4, 1'b0, 1'b1, 32'h80000000);
		wait_drained();

		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			if (i == 0)
				push_word(32'h0, 3'd0, 1'b1, 1'b1, 32'hffffffff);
			push_random_phase(PHASE_ITEMS);
			wait_drained();
		end

		$display("Run covered %0d key words over %0d seed settings plus the reset seed.",
			words_taken, seed_writes);
		$display("%0d hashes compared, %0d mismatches.", hashes_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mh2_pkg.sv
rtl/core/mh2_if.sv
rtl/core/mh2_front.sv
rtl/core/mh2_queue.sv
rtl/core/mh2_back.sv
rtl/core/murmur2_hash_engine_top.sv
sim/murmur2_hash_engine_top_tb.sv
